>>> rtl/mxbt_pkg.sv
// Shared operation codes, status codes and sequencer states for the max-xor trie.
package mxbt_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_EMPTY  = 2'd1;
   localparam logic [1:0] STAT_ABSENT = 2'd2;
   localparam logic [1:0] STAT_FULL   = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_CHK,
      S_QRY,
      S_INS,
      S_ADV,
      S_ARR,
      S_POP,
      S_RM,
      S_RMARR,
      S_FREE
   } state_type;

endpackage

>>> rtl/mxbt_ram.sv
// Generic single-port RAM with registered read data.
module mxbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    re,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                        wdata,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/max_xor_bit_trie.sv
// Max-xor binary trie: insert, remove and maximum-xor query over a key multiset.
//
// Usage: drive req_op and req_value and raise start while busy is low; the item
// is accepted at that edge and busy rises on the next cycle. When the item is
// done, rsp_valid pulses for one cycle with rsp_max_xor and rsp_status, and busy
// is low in that same cycle, so the next item may be started right away.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Structure: one trie level per node-memory access through one single-port node
// RAM with registered read, walked by a small sequencer.
//   query:  one walk down from the root, taking the xor-maximising child.
//   insert: a check walk, then S_ADV, S_ARR and S_INS for each existing
//           level and S_POP and S_INS for each new level.
//   remove: a check walk, then S_RM and S_RMARR for each level down to the
//           first node that empties, then S_FREE for each freed node.
// Reset (synchronous, active high) empties the trie at once: the root has no
// children and the free-node stack is full. Free-stack entries never written
// since reset read as their own position, so no clearing pass is needed.
module max_xor_bit_trie
   import mxbt_pkg::*;
#(
   parameter int KEY_BITS     = 31,
   parameter int MAX_DISTINCT = 1024,
   parameter int COUNT_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [30:0] req_value,
   output logic        rsp_valid,
   output logic [30:0] rsp_max_xor,
   output logic [1:0]  rsp_status
);

   localparam int NODES = KEY_BITS * MAX_DISTINCT;
   localparam int NW    = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int TW    = $clog2(NODES + 1);
   localparam int LW    = $clog2(KEY_BITS + 1);
   localparam int KIW   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
   localparam int EW    = 2 * NW + 2 + COUNT_BITS;

   typedef struct packed {
      logic [NW-1:0]         l1;
      logic [NW-1:0]         l0;
      logic [1:0]            v;
      logic [COUNT_BITS-1:0] cnt;
   } node_type;

   function automatic logic [NW-1:0] link_of(node_type n, logic b);
      return b ? n.l1 : n.l0;
   endfunction

   function automatic node_type set_link(node_type n, logic b, logic [NW-1:0] m);
      node_type r;
      r = n;
      if (b) begin
         r.l1 = m;
      end else begin
         r.l0 = m;
      end
      r.v[b] = 1'b1;
      return r;
   endfunction

   state_type             state_ff, state_in;
   logic [1:0]            op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [KEY_BITS-1:0]   acc_ff, acc_in;
   logic [LW-1:0]         lvl_ff, lvl_in;
   logic [LW-1:0]         rem_ff, rem_in;
   node_type              ent_ff, ent_in;
   node_type              root_ff, root_in;
   logic [NW-1:0]         cur_ff, cur_in;
   logic [NW-1:0]         nxt_ff, nxt_in;
   logic                  at_root_ff, at_root_in;
   logic [TW-1:0]         top_ff, top_in;
   logic [TW-1:0]         lw_ff, lw_in;
   logic [NW-1:0]         pop_pos_ff, pop_pos_in;
   logic                  pop_fresh_ff, pop_fresh_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [30:0]           rsp_max_ff, rsp_max_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   logic                  node_re, node_we;
   logic [NW-1:0]         node_addr;
   node_type              node_wdata;
   logic [EW-1:0]         node_rdata;
   logic                  stk_re, stk_we;
   logic [NW-1:0]         stk_addr;
   logic [NW-1:0]         stk_wdata;
   logic [NW-1:0]         stk_rdata;

   node_type              rd;
   logic                  bit_b, root_b;
   logic                  root_has, need_k, chk_full, chk_has, chk_short;
   logic                  q_alt, q_same, ent_has, free_more, rem_zero, lvl_zero, lvl_one;
   logic [COUNT_BITS-1:0] rd_dec;
   logic [NW-1:0]         pop_m;
   logic [TW-1:0]         pop_t;
   logic [KEY_BITS+30:0]  val_ext, acc_ext;
   logic                  fin;
   logic [1:0]            fin_status;
   node_type              wr_node;

   mxbt_ram #(.WIDTH(EW), .DEPTH(NODES)) u_node_ram (
      .clock (clock),
      .re    (node_re),
      .we    (node_we),
      .addr  (node_addr),
      .wdata (node_wdata),
      .rdata (node_rdata)
   );

   mxbt_ram #(.WIDTH(NW), .DEPTH(NODES)) u_stack_ram (
      .clock (clock),
      .re    (stk_re),
      .we    (stk_we),
      .addr  (stk_addr),
      .wdata (stk_wdata),
      .rdata (stk_rdata)
   );

   assign rd        = node_type'(node_rdata);
   assign bit_b     = key_ff[KIW'(lvl_ff - LW'(1))];
   assign root_b    = key_ff[KIW'(KEY_BITS - 1)];
   assign root_has  = root_ff.v[root_b];
   assign need_k    = 32'(KEY_BITS) > 32'(top_ff);
   assign chk_full  = (op_ff == OP_INSERT) && (rd.cnt == '1);
   assign chk_has   = rd.v[bit_b];
   assign chk_short = 32'(lvl_ff) > 32'(top_ff);
   assign q_alt     = rd.v[~bit_b];
   assign q_same    = rd.v[bit_b];
   assign ent_has   = ent_ff.v[bit_b];
   assign free_more = rd.v != 2'b00;
   assign rem_zero  = rem_ff == '0;
   assign lvl_zero  = lvl_ff == '0;
   assign lvl_one   = lvl_ff == LW'(1);
   assign rd_dec    = rd.cnt - COUNT_BITS'(rd.cnt != '0);
   assign pop_m     = pop_fresh_ff ? pop_pos_ff : stk_rdata;
   assign pop_t     = top_ff - TW'(1);
   assign val_ext   = (KEY_BITS + 31)'(req_value);
   assign acc_ext   = (KEY_BITS + 31)'(acc_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_START;
         end
         S_START: begin
            case (op_ff)
               OP_INSERT: state_in = root_has ? S_CHK : (need_k ? S_IDLE : S_INS);
               OP_REMOVE: state_in = root_has ? S_CHK : S_IDLE;
               OP_QUERY:  state_in = (root_ff.v != 2'b00) ? S_QRY : S_IDLE;
               default:   state_in = S_IDLE;
            endcase
         end
         S_CHK: begin
            if (op_ff == OP_INSERT) begin
               if (chk_full) state_in = S_IDLE;
               else if (lvl_zero) state_in = S_INS;
               else if (chk_has) state_in = S_CHK;
               else if (chk_short) state_in = S_IDLE;
               else state_in = S_INS;
            end else begin
               if (lvl_zero) state_in = S_RM;
               else if (chk_has) state_in = S_CHK;
               else state_in = S_IDLE;
            end
         end
         S_QRY: begin
            if (lvl_zero) state_in = S_IDLE;
            else if (q_alt || q_same) state_in = S_QRY;
            else state_in = S_IDLE;
         end
         S_INS: begin
            if (lvl_zero) state_in = S_IDLE;
            else if (ent_has) state_in = S_ADV;
            else state_in = S_POP;
         end
         S_ADV:   state_in = S_ARR;
         S_ARR:   state_in = S_INS;
         S_POP:   state_in = S_INS;
         S_RM:    state_in = S_RMARR;
         S_RMARR: begin
            if (rd_dec == '0) state_in = S_FREE;
            else if (lvl_one) state_in = S_IDLE;
            else state_in = S_RM;
         end
         S_FREE: begin
            if (!free_more || rem_zero) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      acc_in       = acc_ff;
      lvl_in       = lvl_ff;
      rem_in       = rem_ff;
      ent_in       = ent_ff;
      root_in      = root_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      at_root_in   = at_root_ff;
      top_in       = top_ff;
      lw_in        = lw_ff;
      pop_pos_in   = pop_pos_ff;
      pop_fresh_in = pop_fresh_ff;
      node_re      = 1'b0;
      node_we      = 1'b0;
      node_addr    = cur_ff;
      node_wdata   = ent_ff;
      stk_re       = 1'b0;
      stk_we       = 1'b0;
      stk_addr     = NW'(pop_t);
      stk_wdata    = nxt_ff;
      fin          = 1'b0;
      fin_status   = STAT_OK;
      wr_node      = ent_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_op;
               key_in = val_ext[KEY_BITS-1:0];
               acc_in = '0;
            end
         end
         S_START: begin
            case (op_ff)
               OP_INSERT: begin
                  if (root_has) begin
                     node_re   = 1'b1;
                     node_addr = link_of(root_ff, root_b);
                     lvl_in    = LW'(KEY_BITS - 1);
                  end else if (need_k) begin
                     fin        = 1'b1;
                     fin_status = STAT_FULL;
                  end else begin
                     ent_in     = root_ff;
                     at_root_in = 1'b1;
                     lvl_in     = LW'(KEY_BITS);
                  end
               end
               OP_REMOVE: begin
                  if (root_has) begin
                     node_re   = 1'b1;
                     node_addr = link_of(root_ff, root_b);
                     lvl_in    = LW'(KEY_BITS - 1);
                  end else begin
                     fin        = 1'b1;
                     fin_status = STAT_ABSENT;
                  end
               end
               OP_QUERY: begin
                  if (root_ff.v == 2'b00) begin
                     fin        = 1'b1;
                     fin_status = STAT_EMPTY;
                  end else begin
                     node_re = 1'b1;
                     lvl_in  = LW'(KEY_BITS - 1);
                     if (root_ff.v[~root_b]) begin
                        node_addr                   = link_of(root_ff, ~root_b);
                        acc_in[KIW'(KEY_BITS - 1)] = 1'b1;
                     end else begin
                        node_addr = link_of(root_ff, root_b);
                     end
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end
         S_CHK: begin
            if (op_ff == OP_INSERT) begin
               if (chk_full) begin
                  fin        = 1'b1;
                  fin_status = STAT_FULL;
               end else if (lvl_zero) begin
                  ent_in     = root_ff;
                  at_root_in = 1'b1;
                  lvl_in     = LW'(KEY_BITS);
               end else if (chk_has) begin
                  node_re   = 1'b1;
                  node_addr = link_of(rd, bit_b);
                  lvl_in    = lvl_ff - LW'(1);
               end else if (chk_short) begin
                  fin        = 1'b1;
                  fin_status = STAT_FULL;
               end else begin
                  ent_in     = root_ff;
                  at_root_in = 1'b1;
                  lvl_in     = LW'(KEY_BITS);
               end
            end else begin
               if (lvl_zero) begin
                  ent_in     = root_ff;
                  at_root_in = 1'b1;
                  lvl_in     = LW'(KEY_BITS);
               end else if (chk_has) begin
                  node_re   = 1'b1;
                  node_addr = link_of(rd, bit_b);
                  lvl_in    = lvl_ff - LW'(1);
               end else begin
                  fin        = 1'b1;
                  fin_status = STAT_ABSENT;
               end
            end
         end
         S_QRY: begin
            if (lvl_zero) begin
               fin = 1'b1;
            end else if (q_alt) begin
               node_re                            = 1'b1;
               node_addr                          = link_of(rd, ~bit_b);
               acc_in[KIW'(lvl_ff - LW'(1))]      = 1'b1;
               lvl_in                             = lvl_ff - LW'(1);
            end else if (q_same) begin
               node_re   = 1'b1;
               node_addr = link_of(rd, bit_b);
               lvl_in    = lvl_ff - LW'(1);
            end else begin
               fin = 1'b1;
            end
         end
         S_INS: begin
            if (lvl_zero || ent_has) begin
               if (at_root_ff) begin
                  root_in = ent_ff;
               end else begin
                  node_we = 1'b1;
               end
            end
            if (lvl_zero) begin
               fin = 1'b1;
            end else if (ent_has) begin
               nxt_in = link_of(ent_ff, bit_b);
            end else begin
               stk_re       = 1'b1;
               pop_pos_in   = NW'(pop_t);
               pop_fresh_in = pop_t < lw_ff;
               lw_in        = (pop_t < lw_ff) ? pop_t : lw_ff;
               top_in       = pop_t;
            end
         end
         S_ADV: begin
            node_re    = 1'b1;
            node_addr  = nxt_ff;
            cur_in     = nxt_ff;
            at_root_in = 1'b0;
            lvl_in     = lvl_ff - LW'(1);
         end
         S_ARR: begin
            ent_in     = rd;
            ent_in.cnt = rd.cnt + COUNT_BITS'(1);
         end
         S_POP: begin
            wr_node    = set_link(ent_ff, bit_b, pop_m);
            node_wdata = wr_node;
            if (at_root_ff) begin
               root_in = wr_node;
            end else begin
               node_we = 1'b1;
            end
            ent_in     = '0;
            ent_in.cnt = COUNT_BITS'(1);
            cur_in     = pop_m;
            at_root_in = 1'b0;
            lvl_in     = lvl_ff - LW'(1);
         end
         S_RM: begin
            node_re   = 1'b1;
            node_addr = link_of(ent_ff, bit_b);
            nxt_in    = link_of(ent_ff, bit_b);
         end
         S_RMARR: begin
            if (rd_dec == '0) begin
               wr_node          = ent_ff;
               wr_node.v[bit_b] = 1'b0;
               node_wdata       = wr_node;
               if (at_root_ff) begin
                  root_in = wr_node;
               end else begin
                  node_we = 1'b1;
               end
               rem_in = lvl_ff - LW'(1);
            end else begin
               wr_node     = rd;
               wr_node.cnt = rd_dec;
               node_we     = 1'b1;
               node_addr   = nxt_ff;
               node_wdata  = wr_node;
               ent_in      = wr_node;
               cur_in      = nxt_ff;
               at_root_in  = 1'b0;
               lvl_in      = lvl_ff - LW'(1);
               if (lvl_one) fin = 1'b1;
            end
         end
         S_FREE: begin
            if (top_ff < TW'(NODES)) begin
               stk_we   = 1'b1;
               stk_addr = NW'(top_ff);
               top_in   = top_ff + TW'(1);
            end
            if (!free_more || rem_zero) begin
               fin = 1'b1;
            end else begin
               node_re   = 1'b1;
               node_addr = rd.v[0] ? rd.l0 : rd.l1;
               nxt_in    = rd.v[0] ? rd.l0 : rd.l1;
               rem_in    = rem_ff - LW'(1);
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in  = fin;
      rsp_status_in = fin ? fin_status : rsp_status_ff;
      rsp_max_in    = fin ? ((op_ff == OP_QUERY) ? acc_ext[30:0] : 31'd0) : rsp_max_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         root_ff      <= '0;
         top_ff       <= TW'(NODES);
         lw_ff        <= TW'(NODES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         root_ff      <= root_in;
         top_ff       <= top_in;
         lw_ff        <= lw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      acc_ff        <= acc_in;
      lvl_ff        <= lvl_in;
      rem_ff        <= rem_in;
      ent_ff        <= ent_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      at_root_ff    <= at_root_in;
      pop_pos_ff    <= pop_pos_in;
      pop_fresh_ff  <= pop_fresh_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy        = state_ff != S_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_max_xor = rsp_max_ff;
   assign rsp_status  = rsp_status_ff;

endmodule
